>>> rtl/searchable_deque_assert.svh
// Assertion macros used by the deque checker.
`ifndef SEARCHABLE_DEQUE_ASSERT_SVH
`define SEARCHABLE_DEQUE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdq assertion failed");

// Next-cycle implication, held off during reset.
`define SDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdq assertion failed");

`endif

>>> rtl/sdq_pkg.sv
package sdq_pkg;

    // Request kinds; code 7 is unused and ignored.
    typedef enum logic [2:0] {
        KIND_PUSH_HEAD  = 3'd0,
        KIND_PUSH_TAIL  = 3'd1,
        KIND_POP_HEAD   = 3'd2,
        KIND_POP_TAIL   = 3'd3,
        KIND_FIND       = 3'd4,
        KIND_REMOVE_ALL = 3'd5,
        KIND_CLEAR      = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // What every cell does in a cycle.
    typedef enum logic [2:0] {
        CELL_HOLD  = 3'd0,
        CELL_LEFT  = 3'd1,   // take the entry of the next cell up
        CELL_RIGHT = 3'd2,   // take the entry of the cell below
        CELL_LOAD  = 3'd3,   // the addressed cell takes the operand
        CELL_WALK  = 3'd4    // compacting step of a walk
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       keep;    // walk: the inspected entry survives
    } cell_cmd_t;

    localparam int DATA_W = 32;

endpackage

>>> rtl/searchable_deque.sv
// Bounded double-ended queue of signed 32-bit values with search.
// Request channel (req_valid/req_stall): kind and operand, one beat per request.
// Response channel (rsp_valid/rsp_stall): status, data, position, removed,
// one beat per request, in request order, from an output register.
// The queue sits in a row of DEPTH cells, the head always in cell 0.
// Push head/tail, pop head, clear and the unused kind finish in the accept
// cycle: the response beat appears in the cycle after the request beat.
// Pop tail, find and remove-all on a non-empty queue walk the occupied cells
// through cell 0, one entry per cycle, then rotate the survivors back down,
// one per cycle.
// One request is in flight at a time; a new one is taken once the previous
// response has been written into the output register. A response waiting
// on rsp_stall holds off further requests; with no stall, end-only requests
// can follow one per cycle, the next after a walk once its response is written.
// While rsp_stall is high the response beat holds.
// Reset empties the queue at once (no clearing pass); cell contents are
// left as they are and are never read before being written.
module searchable_deque #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         kind,
    input  logic signed [31:0] operand,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [1:0]         status,
    output logic signed [31:0] data,
    output logic [5:0]         position,
    output logic [6:0]         removed
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_ROTATE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    // control
    state_t        state_reg, state_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] step_reg, step_next;     // walk index, then rotate count
    logic [CW-1:0] kept_reg, kept_next;     // survivors so far
    logic          found_reg, found_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // payload
    logic [2:0]         op_reg, op_next;
    logic signed [31:0] val_reg, val_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic signed [31:0] popped_reg, popped_next;
    sdq_pkg::status_t   status_reg, status_next;
    logic signed [31:0] data_reg, data_next;
    logic [5:0]         position_reg, position_next;
    logic [6:0]         removed_reg, removed_next;

    // cell row
    logic signed [31:0] cell_q [DEPTH];
    logic signed [31:0] prev_in [DEPTH];
    logic signed [31:0] prev0;
    logic signed [31:0] head;
    sdq_pkg::cell_cmd_t cmd;
    logic [AW-1:0]      u_lim, p_lim, load_idx;

    logic rsp_free, accept, full, empty, walk_last, keep;

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE) || !rsp_free;
    assign accept    = req_valid && !req_stall;
    assign full      = (occ_reg == CW'(DEPTH));
    assign empty     = (occ_reg == '0);
    assign head      = cell_q[0];
    assign walk_last = (step_reg == occ_reg - CW'(1));

    // Does the entry now in cell 0 survive this walk step?
    always_comb
    begin
        case (op_reg)
            sdq_pkg::KIND_REMOVE_ALL: keep = (head != val_reg);
            sdq_pkg::KIND_POP_TAIL:   keep = !walk_last;
            default:                  keep = 1'b1;
        endcase
    end

    // Walk limits: cells below u_lim still hold unvisited entries; survivors
    // are packed at the top, in the cells above p_lim.
    assign u_lim    = LAST_IDX - step_reg[AW-1:0];
    assign p_lim    = LAST_IDX - kept_reg[AW-1:0];
    assign load_idx = occ_reg[AW-1:0];
    assign prev0    = (state_reg == ST_ROTATE) ? cell_q[DEPTH-1] : operand;

    always_comb
    begin
        cmd.mode = sdq_pkg::CELL_HOLD;
        cmd.keep = keep;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        sdq_pkg::KIND_PUSH_HEAD:
                            if (!full) cmd.mode = sdq_pkg::CELL_RIGHT;
                        sdq_pkg::KIND_PUSH_TAIL:
                            if (!full) cmd.mode = sdq_pkg::CELL_LOAD;
                        sdq_pkg::KIND_POP_HEAD:
                            if (!empty) cmd.mode = sdq_pkg::CELL_LEFT;
                        default:
                            cmd.mode = sdq_pkg::CELL_HOLD;
                    endcase
                end
            end
            ST_WALK:   cmd.mode = sdq_pkg::CELL_WALK;
            ST_ROTATE: cmd.mode = sdq_pkg::CELL_RIGHT;
            default:   cmd.mode = sdq_pkg::CELL_HOLD;
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign prev_in[g] = prev0;
        end
        else
        begin : g_rest
            assign prev_in[g] = cell_q[g-1];
        end

        sdq_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .u_lim     (u_lim),
            .p_lim     (p_lim),
            .load_idx  (load_idx),
            .operand   (operand),
            .from_next (cell_q[(g + 1) % DEPTH]),
            .from_prev (prev_in[g]),
            .entry     (cell_q[g])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        step_next      = step_reg;
        kept_next      = kept_reg;
        found_next     = found_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        op_next        = op_reg;
        val_next       = val_reg;
        pos_next       = pos_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        position_next  = position_reg;
        removed_next   = removed_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = kind;
                    val_next      = operand;
                    step_next     = '0;
                    kept_next     = '0;
                    found_next    = 1'b0;
                    pos_next      = '0;
                    popped_next   = '0;
                    status_next   = sdq_pkg::STAT_OK;
                    data_next     = '0;
                    position_next = '0;
                    removed_next  = '0;
                    rsp_valid_next = 1'b1;
                    case (kind)
                        sdq_pkg::KIND_PUSH_HEAD, sdq_pkg::KIND_PUSH_TAIL:
                        begin
                            if (full)
                                status_next = sdq_pkg::STAT_FULL;
                            else
                                occ_next = occ_reg + CW'(1);
                        end
                        sdq_pkg::KIND_POP_HEAD:
                        begin
                            if (empty)
                                status_next = sdq_pkg::STAT_EMPTY;
                            else
                            begin
                                data_next = head;
                                occ_next  = occ_reg - CW'(1);
                            end
                        end
                        sdq_pkg::KIND_CLEAR:
                            occ_next = '0;
                        default:
                        begin
                            if (kind inside {sdq_pkg::KIND_POP_TAIL, sdq_pkg::KIND_FIND,
                                             sdq_pkg::KIND_REMOVE_ALL})
                            begin
                                if (!empty)
                                begin
                                    rsp_valid_next = rsp_valid_reg && rsp_stall;
                                    state_next     = ST_WALK;
                                end
                                else if (kind == sdq_pkg::KIND_POP_TAIL)
                                    status_next = sdq_pkg::STAT_EMPTY;
                                else if (kind == sdq_pkg::KIND_FIND)
                                    status_next = sdq_pkg::STAT_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                step_next = step_reg + CW'(1);
                kept_next = kept_reg + CW'(keep);
                if ((op_reg == sdq_pkg::KIND_FIND) && !found_reg && (head == val_reg))
                begin
                    found_next = 1'b1;
                    pos_next   = step_reg;
                end
                if ((op_reg == sdq_pkg::KIND_POP_TAIL) && walk_last)
                    popped_next = head;
                if (walk_last)
                begin
                    step_next  = '0;
                    state_next = (kept_next == '0) ? ST_DONE : ST_ROTATE;
                end
            end

            ST_ROTATE:
            begin
                step_next = step_reg + CW'(1);
                if (step_reg == kept_reg - CW'(1))
                    state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    occ_next       = kept_reg;
                    status_next    = sdq_pkg::STAT_OK;
                    data_next      = '0;
                    position_next  = '0;
                    removed_next   = '0;
                    case (op_reg)
                        sdq_pkg::KIND_POP_TAIL:
                            data_next = popped_reg;
                        sdq_pkg::KIND_FIND:
                        begin
                            if (found_reg)
                                position_next = 6'(pos_reg);
                            else
                                status_next = sdq_pkg::STAT_NOT_FOUND;
                        end
                        sdq_pkg::KIND_REMOVE_ALL:
                            removed_next = 7'(occ_reg - kept_reg);
                        default:
                            status_next = sdq_pkg::STAT_OK;
                    endcase
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            step_reg      <= '0;
            kept_reg      <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            step_reg      <= step_next;
            kept_reg      <= kept_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        popped_reg   <= popped_next;
        status_reg   <= status_next;
        data_reg     <= data_next;
        position_reg <= position_next;
        removed_reg  <= removed_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign data      = data_reg;
    assign position  = position_reg;
    assign removed   = removed_reg;

endmodule

>>> rtl/sdq_cell.sv
module sdq_cell #(
    parameter int DEPTH = 64,
    parameter int IDX   = 0
) (
    input  logic                          clk,
    input  sdq_pkg::cell_cmd_t            cmd,
    input  logic [$clog2(DEPTH)-1:0]      u_lim,
    input  logic [$clog2(DEPTH)-1:0]      p_lim,
    input  logic [$clog2(DEPTH)-1:0]      load_idx,
    input  logic signed [sdq_pkg::DATA_W-1:0] operand,
    input  logic signed [sdq_pkg::DATA_W-1:0] from_next,
    input  logic signed [sdq_pkg::DATA_W-1:0] from_prev,
    output logic signed [sdq_pkg::DATA_W-1:0] entry
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    logic signed [sdq_pkg::DATA_W-1:0] entry_reg;
    logic signed [sdq_pkg::DATA_W-1:0] entry_next;

    always_comb
    begin
        case (cmd.mode)
            sdq_pkg::CELL_HOLD:  entry_next = entry_reg;
            sdq_pkg::CELL_LEFT:  entry_next = from_next;
            sdq_pkg::CELL_RIGHT: entry_next = from_prev;
            sdq_pkg::CELL_LOAD:  entry_next = (MY_IDX == load_idx) ? operand : entry_reg;
            // unvisited part slides down; the survivor part slides down on a keep
            sdq_pkg::CELL_WALK:
                entry_next = ((MY_IDX < u_lim) || (cmd.keep && (MY_IDX >= p_lim)))
                             ? from_next : entry_reg;
            default:             entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> rtl/sdq_checker.sv
`include "searchable_deque_assert.svh"

module sdq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic [2:0]         kind,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic [1:0]         status,
    input logic signed [31:0] data,
    input logic [5:0]         position,
    input logic [6:0]         removed
);

    logic       req_beat;
    logic [2:0] last_kind_reg, last_kind_next;
    logic       last_push;
    logic       quick_kind;

    assign req_beat  = req_valid && !req_stall;
    assign last_push = (last_kind_reg == sdq_pkg::KIND_PUSH_HEAD)
                    || (last_kind_reg == sdq_pkg::KIND_PUSH_TAIL);
    assign quick_kind = (kind == sdq_pkg::KIND_PUSH_HEAD)
                     || (kind == sdq_pkg::KIND_PUSH_TAIL)
                     || (kind == sdq_pkg::KIND_POP_HEAD)
                     || (kind == sdq_pkg::KIND_CLEAR);

    always_comb
    begin
        last_kind_next = req_beat ? kind : last_kind_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_kind_reg <= '0;
        else
            last_kind_reg <= last_kind_next;
    end

    // stalled response beat holds
    `SDQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall,
        rsp_valid && $stable(status) && $stable(data) && $stable(position)
        && $stable(removed))

    // end-only requests answer in the next cycle
    `SDQ_ASSERT_NEXT(a_quick_rsp, clk, rst_n, req_beat && quick_kind, rsp_valid)

    // full status only answers a push
    `SDQ_ASSERT_NOW(a_full_push, clk, rst_n,
        rsp_valid && (status == sdq_pkg::STAT_FULL), last_push)

    // a removal count only comes from remove-all
    `SDQ_ASSERT_NOW(a_removed_src, clk, rst_n, rsp_valid && (removed != 7'd0),
        (last_kind_reg == sdq_pkg::KIND_REMOVE_ALL) && (status == sdq_pkg::STAT_OK))

endmodule

bind searchable_deque sdq_checker u_sdq_checker (.*);
